### design/nmot_pkg.sv
`timescale 1ns / 1ps
package nmot_pkg;
    localparam logic [1:0] VERDICT_PASS     = 2'd0;
    localparam logic [1:0] VERDICT_RESIDUAL = 2'd1;
    localparam logic [1:0] VERDICT_FEW      = 2'd2;
    localparam logic [1:0] VERDICT_NONFIN   = 2'd3;

    localparam logic [2:0] REG_THR_U   = 3'd0;
    localparam logic [2:0] REG_THR_V   = 3'd1;
    localparam logic [2:0] REG_FLOOR   = 3'd2;
    localparam logic [2:0] REG_MIN_NBR = 3'd3;
    localparam logic [2:0] REG_ROW_LEN = 3'd4;
    localparam logic [2:0] REG_ROW_CNT = 3'd5;

    typedef struct packed {
        logic [15:0] row;
        logic [7:0]  col;
        logic        last;
    } t_pos;
endpackage

### design/normalized_median_outlier_test.sv
`timescale 1ns / 1ps
// Normalized median outlier test on a raster-order (u,v) vector field.
// Input channel: i_valid/o_ready with u/v samples and finite flags, one
// request per cycle while o_ready is high. Output channel: o_valid/i_ready
// with outlier, verdict, row, column and frame_last. Only interior positions give
// a result; the result for a centre appears after the request that completes its window.
// Config channel: i_cfg_valid/o_cfg_ready, index and data; always ready.
// Writing row_length or row_count restarts the frame.
// A completing request passes the window register, the queue and four back-end
// stages to o_valid. Throughput: one request per cycle unless the output stalls,
// set by the rank-select median units and a 4-entry queue.
// Reset (synchronous, i_rst_n low) clears counters, queue and pipeline valids
// and loads register defaults; the line store needs no clearing.
// When the receiver stalls the back end holds, the queue fills, then o_ready
// drops; no result is lost.
module normalized_median_outlier_test
    import nmot_pkg::*;
#(
    parameter int RADIUS      = 1,
    parameter int MAX_COLS    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_u_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_v_sample,
    input  logic                          i_u_finite,
    input  logic                          i_v_finite,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_outlier,
    output logic [1:0]                    o_verdict,
    output logic [15:0]                   o_out_row,
    output logic [7:0]                    o_out_col,
    output logic                          o_frame_last
);
    localparam int WW = (2*RADIUS+1)**2*(2*SAMPLE_BITS+2);
    localparam int PW = $bits(t_pos);

    logic [15:0] r_thr_u, r_thr_v, r_floor, r_rows;
    logic [5:0]  r_min;
    logic [8:0]  r_len;
    logic        w_cfg, w_restart;

    assign o_cfg_ready = 1'b1;
    assign w_cfg = i_cfg_valid;
    assign w_restart = w_cfg && (i_cfg_index == REG_ROW_LEN || i_cfg_index == REG_ROW_CNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_u <= 16'd512; r_thr_v <= 16'd512; r_floor <= 16'd26;
            r_min <= '0; r_len <= 9'd256; r_rows <= 16'd256;
        end else if (w_cfg) begin
            case (i_cfg_index)
                REG_THR_U:   r_thr_u <= i_cfg_data;
                REG_THR_V:   r_thr_v <= i_cfg_data;
                REG_FLOOR:   r_floor <= i_cfg_data;
                REG_MIN_NBR: r_min   <= i_cfg_data[5:0];
                REG_ROW_LEN: r_len   <= i_cfg_data[8:0];
                REG_ROW_CNT: r_rows  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_fv, w_fr, w_qv, w_qr;
    logic [WW-1:0] w_fwin, w_qwin;
    t_pos w_fpos, w_qpos, w_opos;

    nmot_front #(.RADIUS(RADIUS), .MAX_COLS(MAX_COLS),
                 .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_restart(w_restart), .i_row_length(r_len),
        .i_row_count(r_rows), .i_valid, .o_ready, .i_u(i_u_sample),
        .i_v(i_v_sample), .i_uf(i_u_finite), .i_vf(i_v_finite),
        .o_valid(w_fv), .i_ready(w_fr), .o_win(w_fwin), .o_pos(w_fpos));

    nmot_fifo #(.WIDTH(WW + PW), .DEPTH(4)) u_fifo (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr),
        .i_data({w_fwin, w_fpos}), .o_valid(w_qv), .i_ready(w_qr),
        .o_data({w_qwin, w_qpos}));

    nmot_back #(.RADIUS(RADIUS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_thr_u(r_thr_u), .i_thr_v(r_thr_v), .i_floor(r_floor),
        .i_min_nbr(r_min), .i_valid(w_qv), .o_ready(w_qr), .i_win(w_qwin),
        .i_pos(w_qpos), .o_valid, .i_ready, .o_outlier, .o_verdict,
        .o_pos(w_opos));

    assign o_out_row    = w_opos.row;
    assign o_out_col    = w_opos.col;
    assign o_frame_last = w_opos.last;
endmodule

### design/nmot_front.sv
`timescale 1ns / 1ps
// Front: line store and window, one column of the window per accepted request.
module nmot_front
    import nmot_pkg::*;
#(
    parameter int RADIUS      = 1,
    parameter int MAX_COLS    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_restart,
    input  logic [8:0]                        i_row_length,
    input  logic [15:0]                       i_row_count,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_u,
    input  logic signed [SAMPLE_BITS-1:0]     i_v,
    input  logic                              i_uf,
    input  logic                              i_vf,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [(2*RADIUS+1)**2*(2*SAMPLE_BITS+2)-1:0] o_win,
    output t_pos                              o_pos
);
    localparam int WIN  = 2 * RADIUS + 1;
    localparam int CW   = 2 * SAMPLE_BITS + 2;
    localparam int CB   = $clog2(MAX_COLS);
    localparam int SW   = (WIN - 1) * CW;

    // eff length/rows
    logic [16:0] w_len_raw, w_len;
    logic [16:0] w_rows;
    always_comb begin
        w_len_raw = {8'd0, i_row_length};
        if (w_len_raw < 17'(WIN)) w_len = 17'(WIN);
        else if (w_len_raw > 17'(MAX_COLS)) w_len = 17'(MAX_COLS);
        else w_len = w_len_raw;
        w_rows = (i_row_count < 16'(WIN)) ? 17'(WIN) : {1'b0, i_row_count};
    end

    logic [15:0] r_row, n_row;
    logic [CB:0] r_col, n_col;
    // one entry per column: the previous rows of that column, oldest in the low slot
    logic [SW-1:0] r_mem [MAX_COLS];
    logic [SW-1:0] r_stk;
    logic [SW-1:0] n_stk;
    logic [CW-1:0] r_win [WIN][WIN];
    logic          r_valid;
    t_pos          r_pos;
    logic [CW-1:0] w_cell;
    logic          w_acc, w_emit;
    logic [CW-1:0] w_colv [WIN];

    assign o_ready = !r_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_cell  = {i_u, i_v, i_uf, i_vf};
    assign w_emit  = ({1'b0, r_row} >= 17'(2 * RADIUS)) &&
                     (r_col >= (CB+1)'(2 * RADIUS));

    // column of the window: stored rows ordered oldest..newest, newest = input
    always_comb begin
        for (int k = 0; k < WIN - 1; k++) w_colv[k] = r_stk[k*CW +: CW];
        w_colv[WIN-1] = w_cell;
    end
    assign n_stk = {w_cell, r_stk[SW-1:CW]};

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (!i_rst_n || i_restart) begin
            n_row = '0;
            n_col = '0;
        end else if (w_acc) begin
            if (17'(r_col) + 17'd1 >= w_len) begin
                n_col = '0;
                if ({1'b0, r_row} + 17'd1 >= w_rows) n_row = '0;
                else n_row = r_row + 16'd1;
            end else begin
                n_col = r_col + (CB+1)'(1);
            end
        end
    end

    // read ahead at the next position so the stack is ready when its request arrives
    always_ff @(posedge i_clk) begin
        if (w_acc) r_mem[r_col[CB-1:0]] <= n_stk;
        r_stk <= r_mem[n_col[CB-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int k = 0; k < WIN; k++) begin
                for (int j = 0; j < WIN - 1; j++) r_win[k][j] <= r_win[k][j+1];
                r_win[k][WIN-1] <= w_colv[k];
            end
            r_pos.row  <= 16'(r_row - 16'(RADIUS));
            r_pos.col  <= 8'(r_col - (CB+1)'(RADIUS));
            r_pos.last <= ({1'b0, r_row} == w_rows - 17'd1) &&
                          (17'(r_col) == w_len - 17'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= w_acc && w_emit;
        end
    end

    always_comb begin
        for (int k = 0; k < WIN; k++)
            for (int j = 0; j < WIN; j++)
                o_win[(k*WIN+j)*CW +: CW] = r_win[k][j];
    end
    assign o_valid = r_valid;
    assign o_pos   = r_pos;
endmodule

### design/nmot_fifo.sv
`timescale 1ns / 1ps
// Short queue between the window front and the judging back.
module nmot_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int AB = $clog2(DEPTH);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AB-1:0] r_wp, r_rp;
    logic [AB:0]   r_cnt;
    logic w_wr, w_rd;

    assign o_ready = r_cnt != (AB+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign w_wr = i_valid && o_ready;
    assign w_rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AB'(DEPTH-1)) ? '0 : r_wp + AB'(1);
            if (w_rd) r_rp <= (r_rp == AB'(DEPTH-1)) ? '0 : r_rp + AB'(1);
            r_cnt <= r_cnt + (AB+1)'(w_wr) - (AB+1)'(w_rd);
        end
    end
endmodule

### design/nmot_median.sv
`timescale 1ns / 1ps
// Twice the median of the valid entries: rank select, registered.
module nmot_median #(
    parameter int N = 8,
    parameter int W = 18
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [N*W-1:0]      i_vals,
    input  logic [N-1:0]        i_ok,
    output logic signed [W:0]   o_med2
);
    localparam int CB = $clog2(N + 1);
    logic signed [W-1:0] w_v [N];
    logic [CB-1:0] w_n, w_lo, w_hi;
    logic [CB-1:0] w_rank [N];
    logic signed [W-1:0] w_a, w_b;
    logic signed [W:0]   r_med2;

    always_comb begin
        w_n = '0;
        for (int i = 0; i < N; i++) begin
            w_v[i] = i_vals[i*W +: W];
            w_n = w_n + CB'(i_ok[i]);
        end
        // stable rank among valid entries
        for (int i = 0; i < N; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < N; j++)
                if (i_ok[j] && j != i &&
                    ((w_v[j] < w_v[i]) || (w_v[j] == w_v[i] && j < i)))
                    w_rank[i] = w_rank[i] + CB'(1);
        end
        w_hi = w_n >> 1;
        w_lo = w_n[0] ? w_hi : w_hi - CB'(1);
        w_a = '0;
        w_b = '0;
        for (int i = 0; i < N; i++) begin
            if (i_ok[i] && w_rank[i] == w_lo) w_a = w_v[i];
            if (i_ok[i] && w_rank[i] == w_hi) w_b = w_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_med2 <= (w_n == '0) ? '0 : (W+1)'(w_a) + (W+1)'(w_b);
    end
    assign o_med2 = r_med2;
endmodule

### design/nmot_back.sv
`timescale 1ns / 1ps
// Back: per-component normalized median test, pipelined, one request a cycle unless the output stalls.
module nmot_back
    import nmot_pkg::*;
#(
    parameter int RADIUS      = 1,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_thr_u,
    input  logic [15:0]         i_thr_v,
    input  logic [15:0]         i_floor,
    input  logic [5:0]          i_min_nbr,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [(2*RADIUS+1)**2*(2*SAMPLE_BITS+2)-1:0] i_win,
    input  t_pos                i_pos,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_outlier,
    output logic [1:0]          o_verdict,
    output t_pos                o_pos
);
    localparam int WIN = 2 * RADIUS + 1;
    localparam int NB  = WIN * WIN - 1;
    localparam int CW  = 2 * SAMPLE_BITS + 2;
    localparam int CTR = RADIUS * WIN + RADIUS;
    localparam int S   = SAMPLE_BITS;
    localparam int NCB = $clog2(NB + 1);
    localparam int RW  = S + 3;      // residual width (signed)

    // pipeline: s1 med, s2 residual median, s3 products, s4 out
    logic [3:0] r_v;
    logic       w_adv;
    assign w_adv   = !r_v[3] || i_ready;
    assign o_ready = w_adv;

    // stage 0 comb
    logic [NB*S-1:0] w_uv, w_vv;
    logic [NB-1:0]   w_uok, w_vok;
    logic [CW-1:0]   w_c;
    logic [NCB-1:0]  w_nu, w_nv;
    always_comb begin
        int m;
        w_nu = '0; w_nv = '0;
        m = 0;
        for (int i = 0; i < WIN * WIN; i++) begin
            if (i != CTR) begin
                w_uv[m*S +: S] = i_win[i*CW + S + 2 +: S];
                w_vv[m*S +: S] = i_win[i*CW + 2 +: S];
                w_uok[m] = i_win[i*CW + 1];
                w_vok[m] = i_win[i*CW];
                w_nu = w_nu + NCB'(i_win[i*CW + 1]);
                w_nv = w_nv + NCB'(i_win[i*CW]);
                m = m + 1;
            end
        end
        w_c = i_win[CTR*CW +: CW];
    end

    // stage 1 regs
    logic signed [S:0] w_mu, w_mv;
    logic [NB*S-1:0] r1_uv, r1_vv;
    logic [NB-1:0] r1_uok, r1_vok;
    logic [CW-1:0] r1_c;
    logic r1_few, r1_nf;
    t_pos r1_pos;
    nmot_median #(.N(NB), .W(S)) u_med_u (.i_clk, .i_en(w_adv), .i_vals(w_uv),
        .i_ok(w_uok), .o_med2(w_mu));
    nmot_median #(.N(NB), .W(S)) u_med_v (.i_clk, .i_en(w_adv), .i_vals(w_vv),
        .i_ok(w_vok), .o_med2(w_mv));
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_uv <= w_uv; r1_vv <= w_vv; r1_uok <= w_uok; r1_vok <= w_vok;
            r1_c <= w_c; r1_pos <= i_pos;
            r1_nf  <= !(w_c[1] && w_c[0]);
            r1_few <= ({{(8-NCB){1'b0}}, w_nu} <= {2'b0, i_min_nbr}) ||
                      ({{(8-NCB){1'b0}}, w_nv} <= {2'b0, i_min_nbr});
        end
    end

    // stage 1 comb: residuals
    logic [NB*RW-1:0] w_ru, w_rv;
    logic signed [RW-1:0] w_t;
    always_comb begin
        w_t = '0;
        for (int i = 0; i < NB; i++) begin
            w_t = RW'($signed(r1_uv[i*S +: S])) * RW'(2) - RW'(w_mu);
            w_ru[i*RW +: RW] = w_t < 0 ? -w_t : w_t;
            w_t = RW'($signed(r1_vv[i*S +: S])) * RW'(2) - RW'(w_mv);
            w_rv[i*RW +: RW] = w_t < 0 ? -w_t : w_t;
        end
    end

    // stage 2
    logic signed [RW:0] w_resu, w_resv;
    logic signed [RW-1:0] r2_du, r2_dv;
    logic r2_few, r2_nf;
    t_pos r2_pos;
    nmot_median #(.N(NB), .W(RW)) u_res_u (.i_clk, .i_en(w_adv), .i_vals(w_ru),
        .i_ok(r1_uok), .o_med2(w_resu));
    nmot_median #(.N(NB), .W(RW)) u_res_v (.i_clk, .i_en(w_adv), .i_vals(w_rv),
        .i_ok(r1_vok), .o_med2(w_resv));
    logic signed [RW-1:0] w_du, w_dv;
    always_comb begin
        w_du = RW'($signed(r1_c[S+2 +: S])) * RW'(2) - RW'(w_mu);
        w_dv = RW'($signed(r1_c[2 +: S])) * RW'(2) - RW'(w_mv);
        if (w_du < 0) w_du = -w_du;
        if (w_dv < 0) w_dv = -w_dv;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_du <= w_du; r2_dv <= w_dv;
            r2_few <= r1_few; r2_nf <= r1_nf; r2_pos <= r1_pos;
        end
    end

    // stage 3: compare 512*dev2 > thr*(res4 + 4*floor)
    localparam int DW = RW + 19;
    logic [RW+2:0] w_denu, w_denv;
    logic [DW-1:0] r3_lu, r3_lv, r3_ru, r3_rv;
    logic r3_few, r3_nf;
    t_pos r3_pos;
    assign w_denu = (RW+3)'(unsigned'(w_resu)) + (RW+3)'({i_floor, 2'b00});
    assign w_denv = (RW+3)'(unsigned'(w_resv)) + (RW+3)'({i_floor, 2'b00});
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_lu <= DW'(unsigned'(r2_du)) << 9;
            r3_lv <= DW'(unsigned'(r2_dv)) << 9;
            r3_ru <= DW'(i_thr_u) * DW'(w_denu);
            r3_rv <= DW'(i_thr_v) * DW'(w_denv);
            r3_few <= r2_few; r3_nf <= r2_nf; r3_pos <= r2_pos;
        end
    end

    logic r4_out;
    logic [1:0] r4_ver;
    t_pos r4_pos;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_pos <= r3_pos;
            if (r3_nf) begin
                r4_out <= 1'b0; r4_ver <= VERDICT_NONFIN;
            end else if (r3_few) begin
                r4_out <= 1'b1; r4_ver <= VERDICT_FEW;
            end else if (r3_lu > r3_ru || r3_lv > r3_rv) begin
                r4_out <= 1'b1; r4_ver <= VERDICT_RESIDUAL;
            end else begin
                r4_out <= 1'b0; r4_ver <= VERDICT_PASS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    assign o_valid   = r_v[3];
    assign o_outlier = r4_out;
    assign o_verdict = r4_ver;
    assign o_pos     = r4_pos;
endmodule
